### hdl/c2d_pkg.sv
// ----------------------------------------------------------------------------
// c2d_pkg: shared types for the 2D convolution block
// Item, queue-slot and result types plus the mode and register codes.
// ----------------------------------------------------------------------------
package c2d_pkg;

   // input mode codes
   localparam logic [1:0] MODE_WEIGHT = 2'd0;
   localparam logic [1:0] MODE_BIAS   = 2'd1;
   localparam logic [1:0] MODE_PIXEL  = 2'd2;
   localparam logic [1:0] MODE_FLUSH  = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_CIN    = 2'd2;
   localparam logic [1:0] CSR_COUT   = 2'd3;

   localparam int NSAMP = 4;   // sample fields carried per pixel

   typedef enum logic [1:0] {
      KIND_WEIGHT,
      KIND_BIAS,
      KIND_PIXEL,
      KIND_FLUSH
   } kind_type;

   typedef struct packed {
      kind_type                         kind;
      logic [3:0]                       oc;
      logic [1:0]                       ic;
      logic [1:0]                       tr;
      logic [1:0]                       tc;
      logic signed [15:0]               weight;
      logic signed [31:0]               bias;
      logic [NSAMP-1:0][15:0]           sample;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } fq_type;

   typedef struct packed {
      logic [15:0]        row;
      logic [10:0]        col;
      logic [3:0]         ch;
      logic signed [47:0] value;
      logic               last;
   } rsp_type;

endpackage

### hdl/c2d_front.sv
// ----------------------------------------------------------------------------
// c2d_front: input side of the convolution block
// Takes request beats, drops loads that fall outside the tables, tags the
// rest by kind and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module c2d_front #(
   parameter int MAX_CIN  = 4,
   parameter int MAX_COUT = 16,
   parameter int KSIZE    = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               hold,
   input  logic [1:0]         mode,
   input  logic [3:0]         oc,
   input  logic [1:0]         ic,
   input  logic [1:0]         tr,
   input  logic [1:0]         tc,
   input  logic signed [15:0] weight,
   input  logic signed [31:0] bias,
   input  logic signed [15:0] s0,
   input  logic signed [15:0] s1,
   input  logic signed [15:0] s2,
   input  logic signed [15:0] s3,
   input  logic               take,
   output c2d_pkg::fq_type    fq
);
   import c2d_pkg::*;

   item_type   q_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   item;
   logic       keep, store, pop;

   always_comb begin
      item.oc        = oc;
      item.ic        = ic;
      item.tr        = tr;
      item.tc        = tc;
      item.weight    = weight;
      item.bias      = bias;
      item.sample[0] = s0;
      item.sample[1] = s1;
      item.sample[2] = s2;
      item.sample[3] = s3;
      unique case (mode)
         MODE_WEIGHT: begin
            item.kind = KIND_WEIGHT;
            keep = (32'(oc) < MAX_COUT) && (32'(ic) < MAX_CIN) &&
                   (32'(tr) < KSIZE) && (32'(tc) < KSIZE);
         end
         MODE_BIAS: begin
            item.kind = KIND_BIAS;
            keep = 32'(oc) < MAX_COUT;
         end
         MODE_PIXEL: begin
            item.kind = KIND_PIXEL;
            keep = 1'b1;
         end
         default: begin
            item.kind = KIND_FLUSH;
            keep = 1'b1;
         end
      endcase
   end

   assign req_full = (cnt_ff == 2'd2) || hold;
   assign store    = req_push && !req_full && keep;
   assign pop      = take && (cnt_ff != 2'd0);

   always_comb begin
      wp_in  = store ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, store} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         q_ff[wp_ff] <= item;
      end
   end

   assign fq.valid = cnt_ff != 2'd0;
   assign fq.item  = q_ff[rp_ff];

endmodule

### hdl/c2d_rspq.sv
// ----------------------------------------------------------------------------
// c2d_rspq: result queue
// First-word-fall-through queue of finished results; reports its fill.
// ----------------------------------------------------------------------------
module c2d_rspq #(
   parameter int DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  c2d_pkg::rsp_type           wdata,
   input  logic                       pop,
   output c2d_pkg::rsp_type           rdata,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import c2d_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rsp_type         mem_ff [DEPTH];
   logic [AW-1:0]   wp_ff, wp_in;
   logic [AW-1:0]   rp_ff, rp_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_pop;

   assign do_pop = pop && (cnt_ff != '0);

   always_comb begin
      wp_in  = (32'(wp_ff) == DEPTH - 1) ? '0 : wp_ff + 1'b1;
      rp_in  = (32'(rp_ff) == DEPTH - 1) ? '0 : rp_ff + 1'b1;
      cnt_in = cnt_ff + CW'(push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_in;
         end
         if (do_pop) begin
            rp_ff <= rp_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wdata;
      end
   end

   assign rdata = mem_ff[rp_ff];
   assign empty = cnt_ff == '0;
   assign count = cnt_ff;

endmodule

### hdl/c2d_back.sv
// ----------------------------------------------------------------------------
// c2d_back: convolution engine
// Registers, table loads, line store, stream position and a serial MAC
// pipeline that walks taps and input channels for each output channel.
// ----------------------------------------------------------------------------
module c2d_back #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_CIN   = 4,
   parameter int MAX_COUT  = 16,
   parameter int KSIZE     = 3,
   parameter int QDEPTH    = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  c2d_pkg::fq_type             fq,
   output logic                        take,
   output logic                        clearing,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [15:0]                 csr_wdata,
   input  logic [$clog2(QDEPTH+1)-1:0] q_count,
   output logic                        rsp_push,
   output c2d_pkg::rsp_type            rsp_data
);
   import c2d_pkg::*;

   localparam int H    = KSIZE / 2;
   localparam int KK   = KSIZE * KSIZE;
   localparam int RING = 2 * H * MAX_WIDTH + 2 * H + 1;
   localparam int RW   = (RING > 1) ? $clog2(RING) : 1;
   localparam int WD   = MAX_COUT * KK * MAX_CIN;
   localparam int WAW  = (WD > 1) ? $clog2(WD) : 1;
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int PW   = $clog2(65536 * MAX_WIDTH + KSIZE * MAX_WIDTH);
   localparam int KW   = (KSIZE > 1) ? $clog2(KSIZE) : 1;
   localparam int ICW  = (MAX_CIN > 1) ? $clog2(MAX_CIN) : 1;
   localparam int CNW  = $clog2(MAX_CIN + 1);
   localparam int OCW  = (MAX_COUT > 1) ? $clog2(MAX_COUT) : 1;
   localparam int CONW = $clog2(MAX_COUT + 1);
   localparam int QCW  = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RUN} state_type;

   typedef struct packed {
      logic               vld;
      logic               first;
      logic               last;
      logic               lastch;
      logic               tapv;
      logic [ICW-1:0]     ic;
      logic [OCW-1:0]     k;
      logic [15:0]        row;
      logic [WW-1:0]      col;
      logic signed [31:0] bias;
   } tag_type;

   function automatic logic [RW-1:0] ring_add(input logic [RW-1:0] a,
                                              input logic [RW-1:0] b);
      logic [RW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (RW+1)'(RING)) begin
         s = s - (RW+1)'(RING);
      end
      return s[RW-1:0];
   endfunction

   // registers as written
   logic [11:0] fw_ff;
   logic [15:0] fh_ff;
   logic [2:0]  cin_reg_ff;
   logic [4:0]  cout_reg_ff;

   // clamped and derived frame values
   logic [12:0]     w_c;
   logic [15:0]     h_c;
   logic [31:0]     dki_c;
   logic [WW-1:0]   w_ff;
   logic [15:0]     h_ff;
   logic [CNW-1:0]  cin_ff;
   logic [CONW-1:0] cout_ff;
   logic [PW-1:0]   area_ff, lag_ff;
   logic [RW-1:0]   off0_ff, dki_ff;

   // stream and sequencer
   state_type       state_ff, state_in;
   logic [WAW-1:0]  clr_ff, clr_in;
   logic [PW-1:0]   p_ff, p_in;
   logic [RW-1:0]   ptr_ff, ptr_in;
   logic [15:0]     orow_ff, orow_in;
   logic [WW-1:0]   ocol_ff, ocol_in;
   logic [15:0]     run_r_ff, run_r_in;
   logic [WW-1:0]   run_c_ff, run_c_in;
   logic [OCW-1:0]  k_ff, k_in;
   logic [KW-1:0]   ki_ff, ki_in, kj_ff, kj_in;
   logic [ICW-1:0]  ic_ff, ic_in;
   logic [WAW-1:0]  wbase_ff, wbase_in;
   logic [RW-1:0]   tap_a_ff, tap_a_in, a0_ff, a0_in;
   logic [QCW-1:0]  resv_ff, resv_in;
   logic signed [31:0] bias_ff [MAX_COUT];

   logic            emit, inframe, pend, start_ok, bias_we, start;
   logic [PW:0]     end_p;
   logic [RW:0]     a0_w;
   logic [RW-1:0]   a0;
   logic [31:0]     wl;
   logic [7:0]      oc8, k8;
   logic            wm_we, lm_we, last_ic, tapv;
   logic [WAW-1:0]  wm_wa, wadr;
   logic signed [15:0] wm_wd;
   logic [MAX_CIN-1:0][15:0] lrow_wd;

   // memories
   logic signed [15:0]        wmem [WD];
   logic [MAX_CIN-1:0][15:0]  lmem [RING];
   logic signed [15:0]        wq_ff;
   logic [MAX_CIN-1:0][15:0]  lrow_ff;

   // MAC pipeline
   tag_type            t1_ff, t1_in, t2_ff;
   logic signed [31:0] prod_ff;
   logic signed [47:0] acc_ff, acc_in;
   logic signed [15:0] samp;

   // clamp registers and work out frame geometry
   always_comb begin
      if (fw_ff == 12'd0) begin
         w_c = 13'd1;
      end else if ({1'b0, fw_ff} > 13'(MAX_WIDTH)) begin
         w_c = 13'(MAX_WIDTH);
      end else begin
         w_c = {1'b0, fw_ff};
      end
      h_c   = (fh_ff == 16'd0) ? 16'd1 : fh_ff;
      dki_c = 32'(w_c) + 32'(RING - 2 * H);
      if (dki_c >= 32'(RING)) begin
         dki_c = dki_c - 32'(RING);
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= WW'(w_c);
      h_ff    <= h_c;
      area_ff <= PW'(32'(h_c) * 32'(w_c));
      lag_ff  <= PW'(32'(H) * 32'(w_c) + 32'(H));
      off0_ff <= RW'(32'(2 * H) * 32'(w_c) + 32'(2 * H));
      dki_ff  <= RW'(dki_c);
      if (cin_reg_ff == 3'd0) begin
         cin_ff <= CNW'(1);
      end else if (32'(cin_reg_ff) > MAX_CIN) begin
         cin_ff <= CNW'(MAX_CIN);
      end else begin
         cin_ff <= CNW'(cin_reg_ff);
      end
      if (cout_reg_ff == 5'd0) begin
         cout_ff <= CONW'(1);
      end else if (32'(cout_reg_ff) > MAX_COUT) begin
         cout_ff <= CONW'(MAX_COUT);
      end else begin
         cout_ff <= CONW'(cout_reg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff       <= 12'd16;
         fh_ff       <= 16'd16;
         cin_reg_ff  <= 3'd3;
         cout_reg_ff <= 5'd16;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH:  fw_ff       <= csr_wdata[11:0];
            CSR_HEIGHT: fh_ff       <= csr_wdata;
            CSR_CIN:    cin_reg_ff  <= csr_wdata[2:0];
            default:    cout_reg_ff <= csr_wdata[4:0];
         endcase
      end
   end

   // stream position tests
   assign emit    = p_ff >= lag_ff;
   assign inframe = p_ff < area_ff;
   assign end_p   = {1'b0, area_ff} + {1'b0, lag_ff} - (PW+1)'(1);
   assign pend    = {1'b0, p_ff} == end_p;
   assign a0_w    = (ptr_ff >= off0_ff) ? {1'b0, ptr_ff} - {1'b0, off0_ff}
                                        : {1'b0, ptr_ff} + (RW+1)'(RING) - {1'b0, off0_ff};
   assign a0      = a0_w[RW-1:0];
   assign start_ok = 32'(q_count) + 32'(resv_ff) + 32'(cout_ff) <= QDEPTH;
   assign oc8     = {4'd0, fq.item.oc};
   assign k8      = 8'(k_ff);
   assign wl      = (32'(fq.item.oc) * KK + 32'(fq.item.tr) * KSIZE + 32'(fq.item.tc))
                    * MAX_CIN + 32'(fq.item.ic);
   assign last_ic = 8'(ic_ff) + 8'd1 == 8'(cin_ff);
   assign wadr    = wbase_ff + WAW'(ic_ff);
   assign tapv    = (18'(run_r_ff) + 18'(ki_ff) >= 18'(H)) &&
                    (18'(run_r_ff) + 18'(ki_ff) < 18'(h_ff) + 18'(H)) &&
                    (16'(run_c_ff) + 16'(kj_ff) >= 16'(H)) &&
                    (16'(run_c_ff) + 16'(kj_ff) < 16'(w_ff) + 16'(H));

   always_comb begin
      for (int l = 0; l < MAX_CIN; l++) begin
         lrow_wd[l] = (l < NSAMP && fq.item.kind == KIND_PIXEL) ?
                      fq.item.sample[l % NSAMP] : 16'd0;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      p_in     = p_ff;
      ptr_in   = ptr_ff;
      orow_in  = orow_ff;
      ocol_in  = ocol_ff;
      run_r_in = run_r_ff;
      run_c_in = run_c_ff;
      k_in     = k_ff;
      ki_in    = ki_ff;
      kj_in    = kj_ff;
      ic_in    = ic_ff;
      wbase_in = wbase_ff;
      tap_a_in = tap_a_ff;
      a0_in    = a0_ff;
      take     = 1'b0;
      bias_we  = 1'b0;
      start    = 1'b0;
      wm_we    = 1'b0;
      wm_wa    = clr_ff;
      wm_wd    = 16'sd0;
      lm_we    = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            wm_we  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == WD - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (fq.valid) begin
               case (fq.item.kind)
                  KIND_WEIGHT: begin
                     take  = 1'b1;
                     wm_we = 1'b1;
                     wm_wa = wl[WAW-1:0];
                     wm_wd = fq.item.weight;
                  end
                  KIND_BIAS: begin
                     take    = 1'b1;
                     bias_we = 1'b1;
                  end
                  default: begin
                     if (!emit || start_ok) begin
                        take  = 1'b1;
                        lm_we = inframe;
                        if (pend) begin
                           p_in   = '0;
                           ptr_in = '0;
                        end else begin
                           p_in   = p_ff + 1'b1;
                           ptr_in = ring_add(ptr_ff, RW'(1));
                        end
                        if (emit) begin
                           start    = 1'b1;
                           run_r_in = orow_ff;
                           run_c_in = ocol_ff;
                           if (pend) begin
                              orow_in = '0;
                              ocol_in = '0;
                           end else if (ocol_ff + 1'b1 == w_ff) begin
                              ocol_in = '0;
                              orow_in = orow_ff + 16'd1;
                           end else begin
                              ocol_in = ocol_ff + 1'b1;
                           end
                           k_in     = '0;
                           ki_in    = '0;
                           kj_in    = '0;
                           ic_in    = '0;
                           wbase_in = '0;
                           tap_a_in = a0;
                           a0_in    = a0;
                           state_in = S_RUN;
                        end
                     end
                  end
               endcase
            end
         end
         S_RUN: begin
            if (!last_ic) begin
               ic_in = ic_ff + 1'b1;
            end else begin
               ic_in    = '0;
               wbase_in = wbase_ff + WAW'(MAX_CIN);
               if (32'(kj_ff) != KSIZE - 1) begin
                  kj_in    = kj_ff + 1'b1;
                  tap_a_in = ring_add(tap_a_ff, RW'(1));
               end else begin
                  kj_in = '0;
                  if (32'(ki_ff) != KSIZE - 1) begin
                     ki_in    = ki_ff + 1'b1;
                     tap_a_in = ring_add(tap_a_ff, dki_ff);
                  end else begin
                     ki_in    = '0;
                     tap_a_in = a0_ff;
                     if (k8 + 8'd1 == 8'(cout_ff)) begin
                        state_in = S_IDLE;
                     end else begin
                        k_in = k_ff + 1'b1;
                     end
                  end
               end
            end
         end
      endcase
      // any register write restarts the frame
      if (csr_we) begin
         p_in    = '0;
         ptr_in  = '0;
         orow_in = '0;
         ocol_in = '0;
      end
   end

   assign clearing = state_ff == S_CLEAR;

   always_comb begin
      resv_in = resv_ff;
      if (start) begin
         resv_in = resv_in + QCW'(cout_ff);
      end
      if (rsp_push) begin
         resv_in = resv_in - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         p_ff     <= '0;
         ptr_ff   <= '0;
         orow_ff  <= '0;
         ocol_ff  <= '0;
         resv_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         p_ff     <= p_in;
         ptr_ff   <= ptr_in;
         orow_ff  <= orow_in;
         ocol_ff  <= ocol_in;
         resv_ff  <= resv_in;
      end
   end

   always_ff @(posedge clock) begin
      run_r_ff <= run_r_in;
      run_c_ff <= run_c_in;
      k_ff     <= k_in;
      ki_ff    <= ki_in;
      kj_ff    <= kj_in;
      ic_ff    <= ic_in;
      wbase_ff <= wbase_in;
      tap_a_ff <= tap_a_in;
      a0_ff    <= a0_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_COUT; i++) begin
            bias_ff[i] <= 32'sd0;
         end
      end else if (bias_we) begin
         bias_ff[oc8[OCW-1:0]] <= fq.item.bias;
      end
   end

   // weight table: one write, one registered read
   always_ff @(posedge clock) begin
      if (wm_we) begin
         wmem[wm_wa] <= wm_wd;
      end
      wq_ff <= wmem[wadr];
   end

   // line store ring: row write per in-frame beat, registered tap read
   always_ff @(posedge clock) begin
      if (lm_we) begin
         lmem[ptr_ff] <= lrow_wd;
      end
      lrow_ff <= lmem[tap_a_ff];
   end

   // issue tag
   always_comb begin
      t1_in.vld    = state_ff == S_RUN;
      t1_in.first  = (ki_ff == '0) && (kj_ff == '0) && (ic_ff == '0);
      t1_in.last   = (32'(ki_ff) == KSIZE - 1) && (32'(kj_ff) == KSIZE - 1) && last_ic;
      t1_in.lastch = k8 + 8'd1 == 8'(cout_ff);
      t1_in.tapv   = tapv;
      t1_in.ic     = ic_ff;
      t1_in.k      = k_ff;
      t1_in.row    = run_r_ff;
      t1_in.col    = run_c_ff;
      t1_in.bias   = bias_ff[k_ff];
   end

   assign samp = lrow_ff[t1_ff.ic];

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
      end else begin
         t1_ff <= t1_in;
         t2_ff <= t1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= t1_ff.tapv ? samp * wq_ff : 32'sd0;
      if (t2_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_in = (t2_ff.first ? 48'(t2_ff.bias) : acc_ff) + 48'(prod_ff);

   assign rsp_push       = t2_ff.vld && t2_ff.last;
   assign rsp_data.row   = t2_ff.row;
   assign rsp_data.col   = 11'(t2_ff.col);
   assign rsp_data.ch    = 4'(t2_ff.k);
   assign rsp_data.value = acc_in;
   assign rsp_data.last  = t2_ff.lastch;

endmodule

### hdl/conv2d_same_padding_bias.sv
// Pipeline: a pixel or flush beat completing a window walks taps and input
//   channels per output channel: reads with t1, product with t2, sum queued.
// Flow: the single multiplier walking taps holds off the next beat until such a
//   beat's walk is done; loads and beats with no result need no walk.
// Reset: synchronous; afterward req_full stays high while the weight table
//   is cleared. Register writes are taken anytime.
// ----------------------------------------------------------------------------
// conv2d_same_padding_bias: streaming multichannel 2D convolution
// Same-padded KSIZE x KSIZE convolution with per-filter bias over raster
// pixels, with line store, weight and bias tables loaded in-band.
// ----------------------------------------------------------------------------
module conv2d_same_padding_bias #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_CIN   = 4,
   parameter int MAX_COUT  = 16,
   parameter int KSIZE     = 3
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_mode,
   input  logic [3:0]         req_out_channel,
   input  logic [1:0]         req_in_channel,
   input  logic [1:0]         req_tap_row,
   input  logic [1:0]         req_tap_col,
   input  logic signed [15:0] req_weight_value,
   input  logic signed [31:0] req_bias_value,
   input  logic signed [15:0] req_sample0,
   input  logic signed [15:0] req_sample1,
   input  logic signed [15:0] req_sample2,
   input  logic signed [15:0] req_sample3,
   // result channel
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [15:0]        rsp_out_row,
   output logic [10:0]        rsp_out_col,
   output logic [3:0]         rsp_result_channel,
   output logic signed [47:0] rsp_value,
   output logic               rsp_last,
   // register writes
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import c2d_pkg::*;

   // result queue holds two positions' worth so the engine rarely waits
   localparam int QDEPTH = 2 * MAX_COUT;
   localparam int QCW    = $clog2(QDEPTH + 1);

   fq_type          fq;
   logic            take, clearing, push;
   rsp_type         wdata, rdata;
   logic [QCW-1:0]  q_count;

   // front: accept, filter, queue
   c2d_front #(
      .MAX_CIN  (MAX_CIN),
      .MAX_COUT (MAX_COUT),
      .KSIZE    (KSIZE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .hold     (clearing),
      .mode     (req_mode),
      .oc       (req_out_channel),
      .ic       (req_in_channel),
      .tr       (req_tap_row),
      .tc       (req_tap_col),
      .weight   (req_weight_value),
      .bias     (req_bias_value),
      .s0       (req_sample0),
      .s1       (req_sample1),
      .s2       (req_sample2),
      .s3       (req_sample3),
      .take     (take),
      .fq       (fq)
   );

   // back: tables, line store, MAC walk; starts a position only with room
   // reserved in the result queue, so it never stalls mid-position
   c2d_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_CIN   (MAX_CIN),
      .MAX_COUT  (MAX_COUT),
      .KSIZE     (KSIZE),
      .QDEPTH    (QDEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .fq        (fq),
      .take      (take),
      .clearing  (clearing),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_count   (q_count),
      .rsp_push  (push),
      .rsp_data  (wdata)
   );

   c2d_rspq #(
      .DEPTH (QDEPTH)
   ) u_rspq (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (wdata),
      .pop   (rsp_pop),
      .rdata (rdata),
      .empty (rsp_empty),
      .count (q_count)
   );

   // one result beat per queue entry
   assign rsp_out_row        = rdata.row;
   assign rsp_out_col        = rdata.col;
   assign rsp_result_channel = rdata.ch;
   assign rsp_value          = rdata.value;
   assign rsp_last           = rdata.last;

endmodule

### hdl/c2d_check.sv
// ----------------------------------------------------------------------------
// c2d_check: port-level checks for the convolution block
// Reset behavior of both channels and hold of a waiting result beat.
// ----------------------------------------------------------------------------
module c2d_check (
   input logic               clock,
   input logic               reset,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic signed [47:0] rsp_value,
   input logic               rsp_last
);

   // weight clear pass blocks input right after reset
   a_reset_full : assert property (@(posedge clock) reset |=> req_full)
      else $error("req_full low right after reset");

   // nothing to deliver right after reset
   a_reset_empty : assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown right after reset");

   a_rsp_stays : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting result beat vanished");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> ($stable(rsp_value) && $stable(rsp_last)))
      else $error("waiting result beat changed");

endmodule

bind conv2d_same_padding_bias c2d_check u_check (.*);

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for conv2d_same_padding_bias
// Streams weight and bias loads, pixel and flush beats. A built-in predictor
// of the same-padded 3x3 convolution queues the expected results. A checker
// compares every popped result with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module testbench;
   import c2d_pkg::*;

   localparam int KSZ   = 3;
   localparam int MAXW  = 2048;
   localparam int RINGD = 2 * (KSZ / 2) * MAXW + 2 * (KSZ / 2) + 1;
   localparam int HOLD  = 600;   // covers the walk of the slowest beat with a margin

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [1:0]         req_mode = MODE_FLUSH;
   logic [3:0]         req_out_channel = '0;
   logic [1:0]         req_in_channel = '0;
   logic [1:0]         req_tap_row = '0;
   logic [1:0]         req_tap_col = '0;
   logic signed [15:0] req_weight_value = '0;
   logic signed [31:0] req_bias_value = '0;
   logic signed [15:0] req_sample0 = '0;
   logic signed [15:0] req_sample1 = '0;
   logic signed [15:0] req_sample2 = '0;
   logic signed [15:0] req_sample3 = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [15:0]        rsp_out_row;
   logic [10:0]        rsp_out_col;
   logic [3:0]         rsp_result_channel;
   logic signed [47:0] rsp_value;
   logic               rsp_last;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = CSR_WIDTH;
   logic [15:0]        csr_wdata = '0;

   conv2d_same_padding_bias dut (.*);

   always #5 clock = ~clock;

   // ---- predictor state ----
   logic [11:0]        frame_w_reg;
   logic [15:0]        frame_h_reg;
   logic [2:0]         cin_reg;
   logic [4:0]         cout_reg;
   logic signed [15:0] kernel [16][4][KSZ][KSZ];
   logic signed [31:0] bias_tab [16];
   logic signed [15:0] line_mem [RINGD][4];
   longint             pos_row, pos_col;

   rsp_type            pending_results [$];

   // idling odds, in percent
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;

   int                 errors = 0;
   int                 beats_sent = 0;
   int                 results_seen = 0;
   int                 frames_run = 0;

   // ---- helpers ----
   task automatic set_phase(input int ph);
      case (ph % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
         default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
   endtask

   function automatic item_type random_beat(input kind_type k);
      item_type it;
      it.kind   = k;
      it.oc     = 4'($urandom);
      it.ic     = 2'($urandom);
      it.tr     = 2'($urandom);
      it.tc     = 2'($urandom);
      it.weight = 16'($urandom);
      it.bias   = 32'($urandom);
      for (int k2 = 0; k2 < NSAMP; k2++) it.sample[k2] = 16'($urandom);
      return it;
   endfunction

   // Works out the results one accepted beat causes and queues them.
   task automatic predict_conv(input item_type it);
      longint  w, h, cin, cout, lag, area, p, q, r, c, ih, iw, lin, acc;
      rsp_type e;
      w    = (frame_w_reg == 0) ? 1 : ((frame_w_reg > MAXW) ? MAXW : frame_w_reg);
      h    = (frame_h_reg == 0) ? 1 : frame_h_reg;
      cin  = (cin_reg == 0) ? 1 : ((cin_reg > 4) ? 4 : cin_reg);
      cout = (cout_reg == 0) ? 1 : ((cout_reg > 16) ? 16 : cout_reg);
      lag  = (KSZ / 2) * w + KSZ / 2;
      area = h * w;
      case (it.kind)
         KIND_WEIGHT: begin
            // taps outside the kernel are dropped
            if (it.tr < KSZ && it.tc < KSZ) kernel[it.oc][it.ic][it.tr][it.tc] = it.weight;
         end
         KIND_BIAS: bias_tab[it.oc] = it.bias;
         default: begin
            p = pos_row * w + pos_col;
            if (p < area)
               for (int k = 0; k < 4; k++)
                  line_mem[p % RINGD][k] = (it.kind == KIND_PIXEL) ? it.sample[k] : 16'sd0;
            if (p >= lag) begin
               q = p - lag;
               r = q / w;
               c = q % w;
               for (int k = 0; k < cout; k++) begin
                  acc = bias_tab[k];
                  for (int ic = 0; ic < cin; ic++)
                     for (int ki = 0; ki < KSZ; ki++)
                        for (int kj = 0; kj < KSZ; kj++) begin
                           ih = r + ki - KSZ / 2;
                           iw = c + kj - KSZ / 2;
                           if (ih >= 0 && ih < h && iw >= 0 && iw < w) begin
                              lin = ih * w + iw;
                              acc += longint'(line_mem[lin % RINGD][ic]) *
                                     longint'(kernel[k][ic][ki][kj]);
                           end
                        end
                  e.row   = 16'(r);
                  e.col   = 11'(c);
                  e.ch    = 4'(k);
                  e.value = 48'(acc);
                  e.last  = (k + 1 == cout);
                  pending_results.push_back(e);
               end
            end
            if (p + 1 >= area + lag) begin
               pos_row = 0;
               pos_col = 0;
            end else begin
               pos_col++;
               if (pos_col >= w) begin
                  pos_col = 0;
                  pos_row++;
               end
            end
         end
      endcase
   endtask

   // Sends one beat; push stays high on return so back-to-back beats need
   // no second assignment in the same step.
   task automatic send_beat(input item_type it);
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_push         <= 1'b1;
      req_mode         <= it.kind;
      req_out_channel  <= it.oc;
      req_in_channel   <= it.ic;
      req_tap_row      <= it.tr;
      req_tap_col      <= it.tc;
      req_weight_value <= it.weight;
      req_bias_value   <= it.bias;
      req_sample0      <= it.sample[0];
      req_sample1      <= it.sample[1];
      req_sample2      <= it.sample[2];
      req_sample3      <= it.sample[3];
      do @(posedge clock); while (req_full);
      predict_conv(it);
      beats_sent++;
   endtask

   task automatic sender_rest();
      req_push <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Quiesce, then rewrite all four registers; any write restarts the frame.
   task automatic write_regs(input logic [15:0] w, h, ci, co);
      logic [15:0] vals [4];
      vals = '{w, h, ci, co};
      sender_rest();
      wait_drained();
      repeat (HOLD) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 2'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         case (2'(i))
            CSR_WIDTH:  frame_w_reg = vals[i][11:0];
            CSR_HEIGHT: frame_h_reg = vals[i];
            CSR_CIN:    cin_reg     = vals[i][2:0];
            default:    cout_reg    = vals[i][4:0];
         endcase
         pos_row = 0;
         pos_col = 0;
      end
      csr_we <= 1'b0;
      frames_run++;
   endtask

   // One frame plus its lag tail, with random content. Tail beats are mostly
   // flushes; in-frame beats are mostly pixels. Loads sneak in now and then.
   task automatic stream_frame(input int w, h, input bit pause_midway);
      int total, area;
      area  = w * h;
      total = area + w + 1;
      for (int p = 0; p < total; p++) begin
         if ($urandom_range(9) == 0)
            send_beat(random_beat($urandom_range(1) ? KIND_WEIGHT : KIND_BIAS));
         if (pause_midway && p == total / 2) begin
            // hold the sender until everything owed has come out
            sender_rest();
            wait_drained();
         end
         if (p < area)
            send_beat(random_beat(($urandom_range(7) == 0) ? KIND_FLUSH : KIND_PIXEL));
         else
            send_beat(random_beat(($urandom_range(3) == 0) ? KIND_PIXEL : KIND_FLUSH));
      end
   endtask

   // ---- result checker and pop driver ----
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected result: row %0d col %0d ch %0d", rsp_out_row, rsp_out_col,
                   rsp_result_channel);
            errors++;
         end else begin
            rsp_type e;
            e = pending_results.pop_front();
            if (rsp_out_row !== e.row) begin
               $error("out_row: expected %0d got %0d", e.row, rsp_out_row);
               errors++;
            end
            if (rsp_out_col !== e.col) begin
               $error("out_col: expected %0d got %0d", e.col, rsp_out_col);
               errors++;
            end
            if (rsp_result_channel !== e.ch) begin
               $error("result_channel: expected %0d got %0d", e.ch, rsp_result_channel);
               errors++;
            end
            if (rsp_value !== e.value) begin
               $error("value: expected %0d got %0d", e.value, rsp_value);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d got %0d", e.last, rsp_last);
               errors++;
            end
         end
      end
      rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---- tests ----
   // Extreme weights, biases and samples on a 3x2 frame with all four input
   // channels; also out-of-kernel loads, a flush inside the frame, a pixel in
   // the tail and a weight load between the frame and its tail.
   task automatic test_directed_frame();
      item_type it;
      write_regs(16'd3, 16'd2, 16'd4, 16'd2);
      it = random_beat(KIND_WEIGHT);
      it.oc = 0; it.ic = 0; it.tr = 0; it.tc = 0; it.weight = 16'sh8000;
      send_beat(it);
      it.oc = 1; it.ic = 3; it.tr = 2; it.tc = 2; it.weight = 16'sh7fff;
      send_beat(it);
      it.tr = 3; it.tc = 1; it.weight = 16'sh1234;   // row outside kernel
      send_beat(it);
      it.tr = 1; it.tc = 3;                         // column outside kernel
      send_beat(it);
      it = random_beat(KIND_BIAS);
      it.oc = 0; it.bias = 32'sh8000_0000;
      send_beat(it);
      it.oc = 1; it.bias = 32'sh7fff_ffff;
      send_beat(it);
      it.oc = 15;                                   // filter not in use
      send_beat(it);
      for (int p = 0; p < 10; p++) begin
         it = random_beat(KIND_PIXEL);
         for (int k = 0; k < NSAMP; k++)
            it.sample[k] = p[0] ? 16'sh7fff : 16'sh8000;
         if (p == 3) it.kind = KIND_FLUSH;            // zeros stored in frame
         if (p == 9) it.kind = KIND_PIXEL;            // samples dropped in tail
         else if (p >= 6) it.kind = KIND_FLUSH;
         send_beat(it);
         if (p == 5) begin
            it = random_beat(KIND_WEIGHT);
            it.oc = 1; it.ic = 0; it.tr = 1; it.tc = 1; it.weight = 16'sh4000;
            send_beat(it);
         end
      end
   endtask

   // Register extremes: zeros clamp up, all-ones clamp down, a tall frame cut
   // short by a rewrite, and the widest line started and cut short.
   task automatic test_register_extremes();
      write_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      stream_frame(1, 1, 1'b0);
      write_regs(16'd3, 16'd2, 16'hffff, 16'hffff);
      stream_frame(3, 2, 1'b0);
      write_regs(16'd2, 16'hffff, 16'd2, 16'd3);
      for (int p = 0; p < 9; p++) send_beat(random_beat(KIND_PIXEL));
      set_phase(0);
      write_regs(16'hffff, 16'd1, 16'd1, 16'd1);
      for (int p = 0; p < 9; p++) send_beat(random_beat(KIND_PIXEL));
   endtask

   // Random small frames across the idling phases, random register contents
   // in the unused upper bits.
   task automatic test_random_frames();
      int w, h, n;
      n = 0;
      while (n < 80) begin
         int start;
         set_phase(frames_run);
         w = $urandom_range(1, 6);
         h = $urandom_range(1, 4);
         write_regs({4'($urandom), 12'(w)}, 16'(h),
                    {13'($urandom), 3'($urandom_range(1, 4))},
                    {11'($urandom), 5'(($urandom_range(3) == 0) ? $urandom_range(1, 16)
                                                               : $urandom_range(1, 4))});
         start = beats_sent;
         for (int i = $urandom_range(2, 8); i > 0; i--)
            send_beat(random_beat($urandom_range(1) ? KIND_WEIGHT : KIND_BIAS));
         stream_frame(w, h, n == 0);
         n += beats_sent - start;
      end
   endtask

   initial begin
      frame_w_reg = 16;
      frame_h_reg = 16;
      cin_reg     = 3;
      cout_reg    = 16;
      pos_row     = 0;
      pos_col     = 0;
      foreach (kernel[a, b, c, d]) kernel[a][b][c][d] = '0;
      foreach (bias_tab[a]) bias_tab[a] = '0;
      foreach (line_mem[a, b]) line_mem[a][b] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      set_phase(0);
      test_directed_frame();
      set_phase(3);
      test_register_extremes();
      test_random_frames();
      sender_rest();
      wait_drained();
      repeat (HOLD) @(posedge clock);
      $display("covered %0d beats, %0d results over %0d register settings",
               beats_sent, results_seen, frames_run);
      $display("idling phases: none, sender, receiver, both; register values clamped");
      if (errors == 0 && pending_results.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   // watchdog
   initial begin
      #40_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule

### sim.f
hdl/c2d_pkg.sv
hdl/c2d_front.sv
hdl/c2d_rspq.sv
hdl/c2d_back.sv
hdl/conv2d_same_padding_bias.sv
hdl/c2d_check.sv
test/testbench.sv
